// ===== rtl/core/ebc_pkg.sv =====
package ebc_pkg;

  // Encoder resolution in counts. Offsets and origins wrap in a word of PosW bits.
  localparam int unsigned EncCounts = 16384;
  localparam int unsigned PosW      = $clog2(EncCounts);
  localparam int unsigned DutyW     = 11;
  localparam int unsigned HalfW     = 13;
  localparam int unsigned MagW      = 10;
  localparam int unsigned StepW     = 3;
  localparam int unsigned PhaseW    = 2;

  // Divider step counter must hold PosW.
  localparam int unsigned CntW = $clog2(PosW + 1);

  localparam logic [MagW-1:0] DutyLimit = MagW'(950);

  // APB register map.
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned RegIdxW = 3;

  typedef enum logic [RegIdxW-1:0] {
    RegSignedDuty   = 3'd0,
    RegStartPos     = 3'd1,
    RegStepWidth    = 3'd2,
    RegHalfStep     = 3'd3,
    RegReverseTable = 3'd4,
    RegRunEnable    = 3'd5
  } reg_idx_e;

  localparam logic [DutyW-1:0] RstSignedDuty = '0;
  localparam logic [PosW-1:0]  RstStartPos   = PosW'(9713);
  localparam logic [PosW-1:0]  RstStepWidth  = PosW'(390);
  localparam logic [HalfW-1:0] RstHalfStep   = HalfW'(195);

  // Phase codes.
  localparam logic [PhaseW-1:0] PhaseA = 2'd0;
  localparam logic [PhaseW-1:0] PhaseB = 2'd1;
  localparam logic [PhaseW-1:0] PhaseC = 2'd2;

  // Driven pair codes.
  localparam logic [StepW-1:0] PairAB = 3'd0;
  localparam logic [StepW-1:0] PairAC = 3'd1;
  localparam logic [StepW-1:0] PairBC = 3'd2;
  localparam logic [StepW-1:0] PairBA = 3'd3;
  localparam logic [StepW-1:0] PairCA = 3'd4;
  localparam logic [StepW-1:0] PairCB = 3'd5;

  typedef struct packed {
    logic [DutyW-1:0] signed_duty;
    logic [PosW-1:0]  origin_pos;
    logic [PosW-1:0]  step_width;
    logic [HalfW-1:0] half_step;
    logic             reverse_table;
    logic             run_enable;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [PosW-1:0] dividend;
    logic [PosW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [StepW-1:0] q_mod6;
  } div_sts_t;

  // Pair lookup for a step in the reversed table; the forward table is the identity.
  function automatic logic [StepW-1:0] rev_pair(input logic [StepW-1:0] step);
    logic [StepW-1:0] p;
    case (step)
      3'd0:    p = PairCA;
      3'd1:    p = PairBA;
      3'd2:    p = PairBC;
      3'd3:    p = PairAC;
      3'd4:    p = PairAB;
      default: p = PairCB;
    endcase
    return p;
  endfunction

  function automatic logic [PhaseW-1:0] pair_high(input logic [StepW-1:0] pair);
    logic [PhaseW-1:0] ph;
    case (pair)
      PairAB, PairAC: ph = PhaseA;
      PairBC, PairBA: ph = PhaseB;
      default:        ph = PhaseC;
    endcase
    return ph;
  endfunction

  function automatic logic [PhaseW-1:0] pair_low(input logic [StepW-1:0] pair);
    logic [PhaseW-1:0] ph;
    case (pair)
      PairAB, PairCB: ph = PhaseB;
      PairAC, PairBC: ph = PhaseC;
      default:        ph = PhaseA;
    endcase
    return ph;
  endfunction

endpackage

// ===== rtl/core/ebc_if.sv =====
interface ebc_in_if;
  logic                       valid;
  logic                       ready;
  logic [ebc_pkg::PosW-1:0]   encoder_position;

  modport source (output valid, output encoder_position, input ready);
  modport sink   (input valid, input encoder_position, output ready);
endinterface

interface ebc_out_if;
  logic                        valid;
  logic                        ready;
  logic [ebc_pkg::StepW-1:0]   step_index;
  logic [ebc_pkg::PhaseW-1:0]  high_phase;
  logic [ebc_pkg::PhaseW-1:0]  low_phase;
  logic [ebc_pkg::MagW-1:0]    high_duty;
  logic [ebc_pkg::StepW-1:0]   pair_code;
  logic                        commutated;

  modport source (output valid, output step_index, output high_phase, output low_phase,
                  output high_duty, output pair_code, output commutated, input ready);
  modport sink   (input valid, input step_index, input high_phase, input low_phase,
                  input high_duty, input pair_code, input commutated, output ready);
endinterface

// ===== rtl/core/encoder_bldc_commutator.sv =====
// Six-step BLDC commutator driven by an absolute encoder.
// Encoder samples arrive as beats on enc_i (valid/ready). Each sample is
// offset from the commutation origin, divided by the step width, and mapped
// to one of six steps. When running is enabled and the step changes, a new
// high/low phase pair and the clamped duty are latched.
// Every accepted sample yields exactly one result beat on res_o, carrying
// the stored step, the driven pair, its phases, its duty and a flag that
// tells whether this sample commutated.
// A result reaches res_o through the bit-serial restoring divider (one quotient
// bit per cycle), a state in which the sequencer sees the divider finish, and a
// commit state. The input reopens after the commit, so a new sample is not
// accepted before the last one has committed.
// A result sits in an output register, so the next sample can be accepted
// and processed while the receiver stalls; the commit of that next sample
// waits until the held result beat has been taken.
// Configuration is written through the APB port at byte address 4*index.
// Reset clears the step, the pair (AB) and the duty, and loads the register
// reset values; no result is pending after reset.
module encoder_bldc_commutator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ebc_pkg::AddrW-1:0]   paddr,
  input  logic [ebc_pkg::DataW-1:0]   pwdata,
  output logic [ebc_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  ebc_in_if.sink                      enc_i,
  ebc_out_if.source                   res_o
);

  localparam int unsigned PW = ebc_pkg::PosW;
  localparam int unsigned SW = ebc_pkg::StepW;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StFin  = 3'b100
  } state_e;

  state_e                     state_q, state_d;
  ebc_pkg::cfg_t              cfg;
  ebc_pkg::div_req_t          div_req;
  ebc_pkg::div_sts_t          div_sts;

  // Commutation state.
  logic [SW-1:0]              step_q, step_d;
  logic [SW-1:0]              pair_q, pair_d;
  logic [ebc_pkg::MagW-1:0]   duty_q, duty_d;

  // Result register.
  logic                       out_vld_q, out_vld_d;
  logic [SW-1:0]              out_step_q, out_step_d;
  logic [SW-1:0]              out_pair_q, out_pair_d;
  logic [ebc_pkg::MagW-1:0]   out_duty_q, out_duty_d;
  logic                       out_com_q, out_com_d;

  logic                       fwd_q, fwd_d;
  logic                       forward;
  logic                       in_beat;
  logic                       out_beat;
  logic                       commit;
  logic [PW-1:0]              half_ext;
  logic [PW-1:0]              origin;
  logic [SW:0]                cand_sum;
  logic [SW-1:0]              cand;
  logic                       change;
  logic [ebc_pkg::DutyW-1:0]  duty_abs;
  logic [ebc_pkg::MagW-1:0]   duty_mag;

  ebc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Negative duty drives forward; the origin then moves up by the half step,
  // otherwise down, and both wrap around the encoder count.
  assign forward  = cfg.signed_duty[ebc_pkg::DutyW-1];
  assign half_ext = PW'(cfg.half_step);
  assign origin   = forward ? (cfg.origin_pos + half_ext)
                            : (cfg.origin_pos - half_ext);

  assign enc_i.ready = (state_q == StIdle);
  assign in_beat     = enc_i.valid && enc_i.ready;
  assign out_beat    = res_o.valid && res_o.ready;

  assign div_req.start    = in_beat;
  assign div_req.dividend = enc_i.encoder_position - origin;
  // A zero step width behaves as a width of one.
  assign div_req.divisor  = (cfg.step_width == '0) ? PW'(1) : cfg.step_width;

  ebc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sts_o  (div_sts)
  );

  // Candidate step: quotient plus one going forward, plus three going backward.
  assign cand_sum = {1'b0, div_sts.q_mod6} + (fwd_q ? 4'd1 : 4'd3);
  assign cand     = (cand_sum >= 4'd6) ? SW'(cand_sum - 4'd6) : SW'(cand_sum);
  assign change   = cfg.run_enable && (cand != step_q);

  // Duty magnitude; the most negative code also clamps to the limit.
  assign duty_abs = forward ? (~cfg.signed_duty + 1'b1) : cfg.signed_duty;
  assign duty_mag = (duty_abs > ebc_pkg::DutyW'(ebc_pkg::DutyLimit))
                    ? ebc_pkg::DutyLimit : duty_abs[ebc_pkg::MagW-1:0];

  // The commit waits for the result register to be free.
  assign commit = (state_q == StFin) && (!out_vld_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    fwd_d   = fwd_q;
    unique case (state_q)
      StIdle: begin
        if (in_beat) begin
          fwd_d   = forward;
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (!div_sts.busy) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (commit) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    step_d = step_q;
    pair_d = pair_q;
    duty_d = duty_q;
    if (commit && change) begin
      step_d = cand;
      pair_d = cfg.reverse_table ? ebc_pkg::rev_pair(cand) : cand;
      duty_d = duty_mag;
    end
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    out_step_d = out_step_q;
    out_pair_d = out_pair_q;
    out_duty_d = out_duty_q;
    out_com_d  = out_com_q;
    if (out_beat) begin
      out_vld_d = 1'b0;
    end
    if (commit) begin
      out_vld_d  = 1'b1;
      out_step_d = step_d;
      out_pair_d = pair_d;
      out_duty_d = duty_d;
      out_com_d  = change;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      step_q    <= '0;
      pair_q    <= ebc_pkg::PairAB;
      duty_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      pair_q    <= pair_d;
      duty_q    <= duty_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_q      <= fwd_d;
    out_step_q <= out_step_d;
    out_pair_q <= out_pair_d;
    out_duty_q <= out_duty_d;
    out_com_q  <= out_com_d;
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.step_index = out_step_q;
  assign res_o.pair_code  = out_pair_q;
  assign res_o.high_phase = ebc_pkg::pair_high(out_pair_q);
  assign res_o.low_phase  = ebc_pkg::pair_low(out_pair_q);
  assign res_o.high_duty  = out_duty_q;
  assign res_o.commutated = out_com_q;

endmodule

// ===== rtl/core/ebc_cfg.sv =====
module ebc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ebc_pkg::AddrW-1:0]   paddr,
  input  logic [ebc_pkg::DataW-1:0]   pwdata,
  output logic [ebc_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output ebc_pkg::cfg_t               cfg_o
);

  ebc_pkg::cfg_t                      cfg_q, cfg_d;
  logic                               wr_en;
  logic [ebc_pkg::RegIdxW-1:0]        idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ebc_pkg::AddrW-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        ebc_pkg::RegSignedDuty:   cfg_d.signed_duty    = pwdata[ebc_pkg::DutyW-1:0];
        ebc_pkg::RegStartPos:     cfg_d.origin_pos     = pwdata[ebc_pkg::PosW-1:0];
        ebc_pkg::RegStepWidth:    cfg_d.step_width     = pwdata[ebc_pkg::PosW-1:0];
        ebc_pkg::RegHalfStep:     cfg_d.half_step      = pwdata[ebc_pkg::HalfW-1:0];
        ebc_pkg::RegReverseTable: cfg_d.reverse_table  = pwdata[0];
        ebc_pkg::RegRunEnable:    cfg_d.run_enable     = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ebc_pkg::RegSignedDuty:   prdata = ebc_pkg::DataW'(cfg_q.signed_duty);
      ebc_pkg::RegStartPos:     prdata = ebc_pkg::DataW'(cfg_q.origin_pos);
      ebc_pkg::RegStepWidth:    prdata = ebc_pkg::DataW'(cfg_q.step_width);
      ebc_pkg::RegHalfStep:     prdata = ebc_pkg::DataW'(cfg_q.half_step);
      ebc_pkg::RegReverseTable: prdata = ebc_pkg::DataW'(cfg_q.reverse_table);
      ebc_pkg::RegRunEnable:    prdata = ebc_pkg::DataW'(cfg_q.run_enable);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.signed_duty    <= ebc_pkg::RstSignedDuty;
      cfg_q.origin_pos     <= ebc_pkg::RstStartPos;
      cfg_q.step_width     <= ebc_pkg::RstStepWidth;
      cfg_q.half_step      <= ebc_pkg::RstHalfStep;
      cfg_q.reverse_table  <= 1'b0;
      cfg_q.run_enable     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/ebc_div.sv =====
module ebc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ebc_pkg::div_req_t  req_i,
  output ebc_pkg::div_sts_t  sts_o
);

  localparam int unsigned W = ebc_pkg::PosW;

  logic                       busy_q, busy_d;
  logic [ebc_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [W-1:0]               dvd_q, dvd_d;
  logic [W-1:0]               dvs_q, dvs_d;
  logic [W-1:0]               rem_q, rem_d;
  logic [ebc_pkg::StepW-1:0]  qm_q, qm_d;

  logic [W:0]                 shifted;
  logic [W:0]                 trial;
  logic                       qbit;
  logic [ebc_pkg::StepW:0]    qm_dbl;

  // One restoring step per cycle, quotient bits most significant first.
  // The quotient itself is never kept, only its residue modulo six.
  assign shifted = {rem_q, dvd_q[W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign qbit    = !trial[W];
  assign qm_dbl  = {qm_q, qbit};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    qm_d   = qm_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = ebc_pkg::CntW'(W);
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      qm_d   = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[W-2:0], 1'b0};
      rem_d = qbit ? trial[W-1:0] : shifted[W-1:0];
      qm_d  = (qm_dbl >= 4'd6) ? ebc_pkg::StepW'(qm_dbl - 4'd6)
                               : ebc_pkg::StepW'(qm_dbl);
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ebc_pkg::CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    qm_q  <= qm_d;
  end

  assign sts_o.busy   = busy_q;
  assign sts_o.q_mod6 = qm_q;

endmodule
